// ===== rtl/core/wfd_pkg.sv =====
package wfd_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_in_buffer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       frame_done;
    logic [1:0] frame_status;
  } out_item_t;

  typedef logic [2:0] phase_t;

  localparam phase_t PH_HDR0   = 3'd0;
  localparam phase_t PH_HDR1   = 3'd1;
  localparam phase_t PH_EXTHI  = 3'd2;
  localparam phase_t PH_EXTLO  = 3'd3;
  localparam phase_t PH_KEY    = 3'd4;
  localparam phase_t PH_DATA   = 3'd5;
  localparam phase_t PH_IGNORE = 3'd6;

  localparam logic [1:0] ST_DATA  = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;
  localparam logic [1:0] ST_SHORT = 2'd3;

  localparam logic [3:0] OPC_MASK   = 4'hF;
  localparam logic [3:0] OPC_CLOSE  = 4'h8;
  localparam logic [6:0] LEN_EXT16  = 7'd126;
  localparam logic [6:0] LEN_EXT64  = 7'd127;

endpackage

// ===== rtl/core/wfd_in_reg.sv =====
module wfd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wfd_pkg::in_item_t in_data,
  input  logic              take,
  output logic              stage_valid,
  output wfd_pkg::in_item_t stage_item
);
  import wfd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready    = !valid_r || take;
  assign valid_nxt   = (in_valid && in_ready) || (valid_r && !take);
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

// ===== rtl/core/wfd_parser.sv =====
module wfd_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  wfd_pkg::in_item_t  item,
  output logic               produce,
  output wfd_pkg::out_item_t res
);
  import wfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kpos_r, kpos_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        has;
  logic [7:0]  pay;
  logic [7:0]  key_byte;
  logic [6:0]  len7;
  logic [1:0]  end_status;
  logic        in_header;

  assign len7     = item.rx_byte[6:0];
  assign key_byte = key_r[{~kpos_r, 3'b000} +: 8];

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    remain_nxt = remain_r;
    key_nxt    = key_r;
    kpos_nxt   = kpos_r;
    status_nxt = status_r;
    has        = 1'b0;
    pay        = 8'h00;
    unique case (phase_r)
      PH_HDR0: begin
        opcode_nxt = item.rx_byte[3:0] & OPC_MASK;
        phase_nxt  = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt = item.rx_byte[7];
        key_nxt    = 32'h0;
        kpos_nxt   = 2'd0;
        if (opcode_r == OPC_CLOSE) begin
          status_nxt = ST_CLOSE;
          phase_nxt  = PH_IGNORE;
        end else if (len7 == LEN_EXT64) begin
          status_nxt = ST_LONG;
          phase_nxt  = PH_IGNORE;
        end else if (len7 == LEN_EXT16) begin
          phase_nxt = PH_EXTHI;
        end else begin
          remain_nxt = {9'd0, len7};
          phase_nxt  = item.rx_byte[7] ? PH_KEY : PH_DATA;
        end
      end
      PH_EXTHI: begin
        remain_nxt = {item.rx_byte, 8'h00};
        phase_nxt  = PH_EXTLO;
      end
      PH_EXTLO: begin
        remain_nxt = {remain_r[15:8], item.rx_byte};
        phase_nxt  = masked_r ? PH_KEY : PH_DATA;
      end
      PH_KEY: begin
        key_nxt  = {key_r[23:0], item.rx_byte};
        kpos_nxt = kpos_r + 2'd1;
        if (kpos_r == 2'd3) begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (remain_r != 16'd0) begin
          pay        = item.rx_byte ^ (masked_r ? key_byte : 8'h00);
          has        = 1'b1;
          kpos_nxt   = kpos_r + 2'd1;
          remain_nxt = remain_r - 16'd1;
        end
      end
      default: begin
      end
    endcase

    in_header = (phase_nxt == PH_HDR1) || (phase_nxt == PH_EXTHI) ||
                (phase_nxt == PH_EXTLO) || (phase_nxt == PH_KEY);
    end_status = in_header ? ST_SHORT : status_nxt;

    if (item.last_in_buffer) begin
      phase_nxt  = PH_HDR0;
      opcode_nxt = 4'h0;
      masked_nxt = 1'b0;
      remain_nxt = 16'd0;
      key_nxt    = 32'h0;
      kpos_nxt   = 2'd0;
      status_nxt = ST_DATA;
    end
  end

  assign produce          = has || item.last_in_buffer;
  assign res.payload_byte = pay;
  assign res.has_byte     = has;
  assign res.frame_done   = item.last_in_buffer;
  assign res.frame_status = item.last_in_buffer ? end_status : ST_DATA;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= 4'h0;
      masked_r <= 1'b0;
      remain_r <= 16'd0;
      key_r    <= 32'h0;
      kpos_r   <= 2'd0;
      status_r <= ST_DATA;
    end else if (step) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      remain_r <= remain_nxt;
      key_r    <= key_nxt;
      kpos_r   <= kpos_nxt;
      status_r <= status_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last_in_buffer |=> phase_r == PH_HDR0 && status_r == ST_DATA)
    else $error("parser state not cleared after the last byte of a buffer");

  a_kpos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_KEY && phase_r != PH_DATA) |-> kpos_r == 2'd0)
    else $error("key position moved outside key or payload phase");

  a_byte_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.has_byte |-> phase_r == PH_DATA && remain_r != 16'd0)
    else $error("payload byte emitted outside payload phase");

  a_ignore_status: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IGNORE |-> (status_r == ST_CLOSE || status_r == ST_LONG))
    else $error("ignore phase entered without close or long status");

endmodule

// ===== rtl/core/wfd_out_reg.sv =====
module wfd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  wfd_pkg::out_item_t res,
  output logic               space,
  output logic               out_valid,
  input  logic               out_ready,
  output wfd_pkg::out_item_t out_data
);
  import wfd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign space     = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_data  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

endmodule

// ===== rtl/core/websocket_frame_decoder.sv =====
// Channel   Ports                            Moves
// input     in_valid, in_ready, in_data      one buffer byte and its last flag
// output    out_valid, out_ready, out_data   one payload byte and/or end status
//
// Each item is held in the input register, and its result is held in the result
// register, from which it is presented.
// One item is accepted per cycle while the result side keeps up.
// Reset returns the parser to the first header byte of a new buffer.
// A stalled result holds the parser and input register; in_ready drops
// only when both registers are full.
module websocket_frame_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wfd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wfd_pkg::out_item_t out_data
);
  import wfd_pkg::*;

  logic      stage_valid;
  in_item_t  stage_item;
  logic      space;
  logic      step;
  logic      produce;
  out_item_t res;

  assign step = stage_valid && space;

  wfd_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .take        (step),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  wfd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .item    (stage_item),
    .produce (produce),
    .res     (res)
  );

  wfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && produce),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/websocket_frame_decoder_checker.sv =====
module websocket_frame_decoder_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  wfd_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  wfd_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 results_checked
);
  import wfd_pkg::*;

  phase_t      hdr_phase;
  logic [3:0]  opcode;
  logic        masked;
  logic [15:0] bytes_left;
  logic [31:0] key;
  logic [1:0]  key_pos;
  logic [1:0]  held_status;

  out_item_t   expected_q[$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
  end

  function automatic void clear_frame();
    hdr_phase   = PH_HDR0;
    opcode      = '0;
    masked      = 1'b0;
    bytes_left  = '0;
    key         = '0;
    key_pos     = '0;
    held_status = ST_DATA;
  endfunction

  // Advances the frame parser by one byte; returns 1 when the byte yields a result.
  function automatic logic decode_byte(input in_item_t it, output out_item_t res);
    logic       has;
    logic [7:0] pay;
    logic [7:0] key_byte;
    has = 1'b0;
    pay = '0;
    res = '0;
    case (hdr_phase)
      PH_HDR0: begin
        opcode    = it.rx_byte[3:0];
        hdr_phase = PH_HDR1;
      end
      PH_HDR1: begin
        masked  = it.rx_byte[7];
        key     = '0;
        key_pos = '0;
        if (opcode == OPC_CLOSE) begin
          held_status = ST_CLOSE;
          hdr_phase   = PH_IGNORE;
        end else if (it.rx_byte[6:0] == LEN_EXT64) begin
          held_status = ST_LONG;
          hdr_phase   = PH_IGNORE;
        end else if (it.rx_byte[6:0] == LEN_EXT16) begin
          hdr_phase = PH_EXTHI;
        end else begin
          bytes_left = {9'd0, it.rx_byte[6:0]};
          hdr_phase  = masked ? PH_KEY : PH_DATA;
        end
      end
      PH_EXTHI: begin
        bytes_left = {it.rx_byte, 8'h00};
        hdr_phase  = PH_EXTLO;
      end
      PH_EXTLO: begin
        bytes_left[7:0] = it.rx_byte;
        hdr_phase       = masked ? PH_KEY : PH_DATA;
      end
      PH_KEY: begin
        key     = {key[23:0], it.rx_byte};
        key_pos = key_pos + 2'd1;
        if (key_pos == 2'd0) begin
          hdr_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        if (bytes_left != 16'd0) begin
          key_byte   = masked ? key[31 - 8 * key_pos -: 8] : 8'h00;
          pay        = it.rx_byte ^ key_byte;
          has        = 1'b1;
          key_pos    = key_pos + 2'd1;
          bytes_left = bytes_left - 16'd1;
        end
      end
      default: begin
      end
    endcase

    if (!it.last_in_buffer) begin
      res.payload_byte = pay;
      res.has_byte     = has;
      return has;
    end

    res.payload_byte = pay;
    res.has_byte     = has;
    res.frame_done   = 1'b1;
    if (hdr_phase == PH_HDR1 || hdr_phase == PH_EXTHI ||
        hdr_phase == PH_EXTLO || hdr_phase == PH_KEY) begin
      res.frame_status = ST_SHORT;
    end else begin
      res.frame_status = held_status;
    end
    clear_frame();
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t next_res;
    if (!rst_n) begin
      clear_frame();
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_checked <= results_checked + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result: payload_byte %0h has_byte %0b frame_done %0b status %0d",
                 out_data.payload_byte, out_data.has_byte, out_data.frame_done,
                 out_data.frame_status);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_data.payload_byte !== want.payload_byte ||
              out_data.has_byte !== want.has_byte ||
              out_data.frame_done !== want.frame_done ||
              out_data.frame_status !== want.frame_status) begin
            fail_count <= fail_count + 1;
          end
          if (out_data.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                   out_data.payload_byte);
          end
          if (out_data.has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, out_data.has_byte);
          end
          if (out_data.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done, out_data.frame_done);
          end
          if (out_data.frame_status !== want.frame_status) begin
            $error("frame_status: expected %0d, got %0d", want.frame_status,
                   out_data.frame_status);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_data, next_res)) begin
          expected_q = {expected_q, next_res};
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== tb/tb_websocket_frame_decoder.sv =====
module tb_websocket_frame_decoder;
  import wfd_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int TARGET_BYTES = 550;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_SPARSE,
    RDY_PERIODIC
  } ready_mode_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int results_checked;

  logic [7:0] frame_bytes[$];
  int         burst_left;
  int         bytes_sent;
  int         useful_bytes;
  int         buffers_sent;
  int         n_noise, n_close, n_long, n_cut, n_data;
  int         idle_cycles;
  logic [9:0] rx_cycle = '0;

  websocket_frame_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  websocket_frame_decoder_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    ready_mode_e mode;
    mode = ready_mode_e'(rx_cycle[9:8]);
    rx_cycle <= rx_cycle + 10'd1;
    case (mode)
      RDY_ALWAYS:   out_ready <= 1'b1;
      RDY_MOSTLY:   out_ready <= ($urandom_range(0, 9) < 7);
      RDY_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
      RDY_PERIODIC: out_ready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
      default:      out_ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void append_byte(input logic [7:0] b);
    frame_bytes = {frame_bytes, b};
  endfunction

  task automatic send_item(input in_item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk iff (in_valid && in_ready));
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame();
    in_item_t it;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      it.rx_byte        = frame_bytes[i];
      it.last_in_buffer = (i == frame_bytes.size() - 1);
      send_item(it);
    end
    buffers_sent++;
  endtask

  // Builds one random buffer; ignored tracks bytes the parser skips.
  task automatic build_random_frame(output int ignored);
    int          kind;
    int          sel;
    int          hdr_len;
    int          body;
    int          keep;
    int          r;
    logic        masked;
    logic        is_ext;
    logic [3:0]  opc;
    logic [15:0] dlen;
    frame_bytes.delete();
    ignored = 0;
    kind    = $urandom_range(0, 99);
    masked  = 1'($urandom_range(0, 1));
    opc     = 4'($urandom_range(0, 15));
    if (opc == OPC_CLOSE) begin
      opc = opc ^ 4'h1;
    end
    if (kind < 10) begin
      n_noise++;
      repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
    end else if (kind < 20) begin
      n_close++;
      append_byte({4'($urandom_range(0, 15)), OPC_CLOSE});
      append_byte(8'($urandom_range(0, 255)));
      ignored = $urandom_range(0, 4);
      repeat (ignored) append_byte(8'($urandom_range(0, 255)));
    end else if (kind < 28) begin
      n_long++;
      append_byte({4'($urandom_range(0, 15)), opc});
      append_byte({masked, LEN_EXT64});
      ignored = $urandom_range(0, 3);
      repeat (ignored) append_byte(8'($urandom_range(0, 255)));
    end else begin
      sel    = $urandom_range(0, 19);
      is_ext = (sel >= 13);
      if (sel < 12) begin
        dlen = 16'($urandom_range(0, 20));
      end else if (sel == 12) begin
        dlen = 16'($urandom_range(100, 125));
      end else if (sel < 18) begin
        dlen = 16'($urandom_range(0, 40));
      end else begin
        dlen = 16'($urandom_range(0, 65535));
      end
      append_byte({4'($urandom_range(0, 15)), opc});
      append_byte({masked, is_ext ? LEN_EXT16 : dlen[6:0]});
      if (is_ext) begin
        append_byte(dlen[15:8]);
        append_byte(dlen[7:0]);
      end
      if (masked) begin
        repeat (4) append_byte(8'($urandom_range(0, 255)));
      end
      hdr_len = frame_bytes.size();
      if (kind < 36) begin
        n_cut++;
        keep = $urandom_range(1, hdr_len - 1);
        while (frame_bytes.size() > keep) frame_bytes.pop_back();
      end else begin
        n_data++;
        r = $urandom_range(0, 9);
        if (is_ext && dlen > 40) begin
          body = $urandom_range(0, 24);
        end else if (r < 6) begin
          body = int'(dlen);
        end else if (r < 8) begin
          ignored = $urandom_range(1, 3);
          body    = int'(dlen) + ignored;
        end else begin
          body = $urandom_range(0, dlen);
        end
        repeat (body) append_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int skipped;
    burst_left   = 0;
    bytes_sent   = 0;
    useful_bytes = 0;
    buffers_sent = 0;
    idle_cycles  = 0;
    n_noise = 0;
    n_close = 0;
    n_long  = 0;
    n_cut   = 0;
    n_data  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    frame_bytes = '{8'h8F};
    send_frame();
    frame_bytes = '{8'h88, 8'hFE, 8'h12};
    send_frame();
    frame_bytes = '{8'h02, 8'h7F, 8'hAB};
    send_frame();
    frame_bytes = '{8'h01, 8'h7E, 8'h00};
    send_frame();
    frame_bytes = '{8'h01, 8'h85, 8'h11};
    send_frame();
    frame_bytes = '{8'h81, 8'h84, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF};
    send_frame();
    frame_bytes = '{8'h00, 8'h01, 8'h00, 8'hFF};
    send_frame();
    useful_bytes = bytes_sent;

    while (useful_bytes < TARGET_BYTES) begin
      build_random_frame(skipped);
      send_frame();
      useful_bytes += frame_bytes.size() - skipped;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Drove %0d bytes in %0d buffers; %0d results checked.",
             bytes_sent, buffers_sent, results_checked);
    $display("Random buffers: %0d data, %0d close, %0d 64-bit length, %0d cut header,",
             n_data, n_close, n_long, n_cut);
    $display("and %0d noise.", n_noise);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
